// File: src/two_sided_request_matcher_macros.svh
// Assertion macros for the two-sided request matcher.
// Included by the top level, which carries the concurrent assertions; needs no package.
`ifndef TWO_SIDED_REQUEST_MATCHER_MACROS_SVH
`define TWO_SIDED_REQUEST_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TSRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tsrm_pkg.sv
// Shared types and constants of the two-sided request matcher.
// Used by tsrm_cell and the top level; depends on nothing.
`default_nettype none

package tsrm_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 256;

   localparam int DATE_W   = 30;
   localparam int PERSON_W = 40;
   localparam int TITLE_W  = 64;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_QUEUED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MATCHED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

   localparam logic SIDE_A = 1'b0;

   // One pending request as held in a table cell.
   typedef struct packed {
      logic                side;
      logic [PERSON_W-1:0] person;
      logic [TITLE_W-1:0]  title;
   } entry_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic cmp_en;   // latch the match flag against the incoming word
      logic upd_en;   // apply removal or append
      logic no_hit;   // no cell matched the current word
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_UPD  = 2'b10
   } state_type;

endpackage

`default_nettype wire

// File: src/tsrm_cell.sv
// One cell of the pending-request table: storage, match compare, shift and append.
// Depends on tsrm_pkg.
`default_nettype none

module tsrm_cell (
   input  wire                           clock,
   input  wire                           reset,
   input  wire tsrm_pkg::cell_ctrl_type  ctrl,
   input  wire tsrm_pkg::entry_type      cmp_entry,
   input  wire tsrm_pkg::entry_type      new_entry,
   input  wire                           shift,
   input  wire                           prev_valid,
   input  wire                           nxt_valid,
   input  wire tsrm_pkg::entry_type      nxt_entry,
   output logic                          valid,
   output tsrm_pkg::entry_type           entry,
   output logic                          hit
);

   logic                valid_ff, valid_in;
   tsrm_pkg::entry_type entry_ff, entry_in;
   logic                hit_ff, hit_in;
   logic                match_now;
   logic                append;

   // A pending entry matches when sides differ, titles agree and persons differ.
   assign match_now = valid_ff && (entry_ff.side != cmp_entry.side) &&
                      (entry_ff.person != cmp_entry.person) &&
                      (entry_ff.title == cmp_entry.title);

   // The first empty cell takes a word that found no partner.
   assign append = ctrl.no_hit && !valid_ff && prev_valid;

   always_comb begin
      hit_in   = ctrl.cmp_en ? match_now : hit_ff;
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctrl.upd_en) begin
         if (shift) begin
            valid_in = nxt_valid;
            entry_in = nxt_entry;
         end else if (append) begin
            valid_in = 1'b1;
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

`default_nettype wire

// File: src/tsrm_prefix.sv
// Inclusive prefix OR over the cells' match flags, in log2(depth) levels.
// Depends on nothing but its parameter.
`default_nettype none

module tsrm_prefix #(
   parameter int QUEUE_DEPTH = 256
) (
   input  wire  [QUEUE_DEPTH-1:0] hits,
   output logic [QUEUE_DEPTH-1:0] any_upto
);

   localparam int LEVELS = $clog2(QUEUE_DEPTH);

   logic [QUEUE_DEPTH-1:0] level [LEVELS+1];

   assign level[0] = hits;

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_bit
         if (i >= (1 << l)) begin : g_or
            assign level[l+1][i] = level[l][i] | level[l][i-(1<<l)];
         end else begin : g_pass
            assign level[l+1][i] = level[l][i];
         end
      end
   end

   assign any_upto = level[LEVELS];

endmodule

`default_nettype wire

// File: src/two_sided_request_matcher.sv
// Top level of the two-sided request matcher: sequencer, cell chain and result register.
// Depends on tsrm_pkg, tsrm_cell, tsrm_prefix and two_sided_request_matcher_macros.svh.
//
// The block keeps a table of pending requests in a chain of QUEUE_DEPTH cells, oldest in
// cell 0. Each request word is compared against every cell in the cycle it is accepted,
// and each cell registers its own match flag. In the update state that follows, the oldest
// matching cell is picked through a prefix OR network, that cell is removed and all younger
// cells move one place toward cell 0; on a miss the word is written into the first empty
// cell, or dropped when the table is full. One result word is written per request into an
// output register. A request is compared in the idle state and picked and compacted in the
// update state, so the block takes no new word until the update of the last one is done.
// The update state waits while the previous result has not been taken. The table needs no
// clearing pass: reset clears every cell's valid bit at once.
`default_nettype none
`include "two_sided_request_matcher_macros.svh"

module two_sided_request_matcher #(
   parameter int QUEUE_DEPTH = tsrm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [tsrm_pkg::DATE_W-1:0]      req_date,
   input  wire                              req_side,
   input  wire  [tsrm_pkg::PERSON_W-1:0]    req_person_key,
   input  wire  [tsrm_pkg::TITLE_W-1:0]     req_title_key,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [tsrm_pkg::STATUS_W-1:0]    rsp_status,
   output logic [tsrm_pkg::DATE_W-1:0]      rsp_match_date,
   output logic [tsrm_pkg::PERSON_W-1:0]    rsp_a_person,
   output logic [tsrm_pkg::PERSON_W-1:0]    rsp_b_person
);

   tsrm_pkg::state_type state_ff, state_in;

   // Request held from the compare cycle to the update cycle.
   logic [tsrm_pkg::DATE_W-1:0] req_date_ff;
   tsrm_pkg::entry_type         req_entry_ff;
   tsrm_pkg::entry_type         cmp_entry;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tsrm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [tsrm_pkg::DATE_W-1:0]   rsp_date_ff, rsp_date_in;
   logic [tsrm_pkg::PERSON_W-1:0] rsp_a_ff, rsp_a_in;
   logic [tsrm_pkg::PERSON_W-1:0] rsp_b_ff, rsp_b_in;

   logic                   accept;
   logic                   advance;
   logic                   any_hit;
   logic                   table_full;
   logic [QUEUE_DEPTH-1:0] cell_valid;
   logic [QUEUE_DEPTH-1:0] cell_hit;
   logic [QUEUE_DEPTH-1:0] hit_upto;
   logic [QUEUE_DEPTH-1:0] first_hit;
   logic [tsrm_pkg::PERSON_W-1:0] other_person;
   tsrm_pkg::entry_type    cell_entry [QUEUE_DEPTH];
   tsrm_pkg::cell_ctrl_type ctrl;

   assign req_ready = (state_ff == tsrm_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   // The update cycle needs a free output register.
   assign advance = (state_ff == tsrm_pkg::ST_UPD) && (!rsp_valid_ff || rsp_ready);

   assign cmp_entry.side   = req_side;
   assign cmp_entry.person = req_person_key;
   assign cmp_entry.title  = req_title_key;

   assign any_hit    = hit_upto[QUEUE_DEPTH-1];
   assign table_full = cell_valid[QUEUE_DEPTH-1];

   assign ctrl.cmp_en = accept;
   assign ctrl.upd_en = advance;
   assign ctrl.no_hit = !any_hit;

   // The oldest match is the one with no match in any older cell.
   assign first_hit = cell_hit & ~{hit_upto[QUEUE_DEPTH-2:0], 1'b0};

   tsrm_prefix #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_prefix (
      .hits     (cell_hit),
      .any_upto (hit_upto)
   );

   // Cell i moves its younger neighbor in when the removed cell is at i or older.
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                prev_valid;
      logic                nxt_valid;
      tsrm_pkg::entry_type nxt_entry;

      if (g == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = cell_valid[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign nxt_valid = 1'b0;
         assign nxt_entry = cell_entry[g];
      end else begin : g_link
         assign nxt_valid = cell_valid[g+1];
         assign nxt_entry = cell_entry[g+1];
      end

      tsrm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cmp_entry  (cmp_entry),
         .new_entry  (req_entry_ff),
         .shift      (hit_upto[g]),
         .prev_valid (prev_valid),
         .nxt_valid  (nxt_valid),
         .nxt_entry  (nxt_entry),
         .valid      (cell_valid[g]),
         .entry      (cell_entry[g]),
         .hit        (cell_hit[g])
      );
   end

   // Person key of the removed entry, selected by the one-hot pick.
   always_comb begin
      other_person = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         other_person = other_person |
                        ({tsrm_pkg::PERSON_W{first_hit[i]}} & cell_entry[i].person);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsrm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tsrm_pkg::ST_UPD;
            end
         end
         tsrm_pkg::ST_UPD: begin
            if (advance) begin
               state_in = tsrm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsrm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_date_in   = rsp_date_ff;
      rsp_a_in      = rsp_a_ff;
      rsp_b_in      = rsp_b_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (any_hit) begin
            rsp_status_in = tsrm_pkg::STATUS_MATCHED;
            rsp_date_in   = req_date_ff;
            if (req_entry_ff.side == tsrm_pkg::SIDE_A) begin
               rsp_a_in = req_entry_ff.person;
               rsp_b_in = other_person;
            end else begin
               rsp_a_in = other_person;
               rsp_b_in = req_entry_ff.person;
            end
         end else begin
            rsp_status_in = table_full ? tsrm_pkg::STATUS_DROPPED : tsrm_pkg::STATUS_QUEUED;
            rsp_date_in   = '0;
            rsp_a_in      = '0;
            rsp_b_in      = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsrm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_date_ff  <= req_date;
         req_entry_ff <= cmp_entry;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_date_ff   <= rsp_date_in;
      rsp_a_ff      <= rsp_a_in;
      rsp_b_ff      <= rsp_b_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_match_date = rsp_date_ff;
   assign rsp_a_person   = rsp_a_ff;
   assign rsp_b_person   = rsp_b_ff;

   // Pending entries stay packed toward cell 0.
   `TSRM_ASSERT_NOW(a_packed, clock, reset, 1'b1,
      ((cell_valid >> 1) & ~cell_valid) == '0, "table has a hole")

   // At most one cell is picked for removal.
   `TSRM_ASSERT_NOW(a_one_pick, clock, reset, state_ff == tsrm_pkg::ST_UPD,
      $onehot0(first_hit), "more than one cell picked")

   // A match removes exactly one pending entry.
   `TSRM_ASSERT_NEXT(a_remove_one, clock, reset, advance && any_hit,
      $countones(cell_valid) == $past($countones(cell_valid)) - 1,
      "match did not remove exactly one entry")

   // A matched update leaves a matched result in the output register.
   `TSRM_ASSERT_NEXT(a_match_rsp, clock, reset, advance && any_hit,
      rsp_valid && rsp_status == tsrm_pkg::STATUS_MATCHED, "match result missing")

endmodule

`default_nettype wire
